@@ rtl/bdq_pkg.sv @@
`default_nettype none

package bdq_pkg;

  // default store depth
  localparam int DEPTH_DEF = 16;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 4;
  localparam int CNT_W    = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic                    hit;
    logic [POS_W-1:0]        position;
    logic [CNT_W-1:0]        count;
    logic                    is_empty;
    logic signed [VAL_W-1:0] back_value;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_BACK,
    S_BACK_WAIT,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/bdq_ram.sv @@
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bounded_deque_with_search.sv @@
// Flow: an input word is taken in S_IDLE and applied in S_EXEC; the back entry is read
//   in S_BACK, the result word is built in S_BACK_WAIT and offered in S_OUT. A find runs
//   S_FIND between S_EXEC and S_BACK, one store read per entry up to the first hit, and skips it on an empty store.
// One word at a time: the next input word is taken the cycle after the result word leaves,
//   and S_OUT holds the result word while out_stall is high.
// Reset: synchronous, active low; the deque comes up empty, store contents undefined.
`default_nettype none

module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // control state
  state_t           state_r, state_nxt;
  logic [AW-1:0]    front_r, front_nxt;
  logic [CW-1:0]    occ_r, occ_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;

  // item and result payload
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [CW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic             hit_r, hit_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  out_word_t        out_r, out_nxt;

  // store port
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic             match;
  logic             find_done;

  // circular slot: base + offset wrapped at DEPTH (sum stays below 2*DEPTH)
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    begin
      sum = SW'(base) + SW'(off);
      if (sum >= DEPTH_S) begin
        sum = sum - DEPTH_S;
      end
      slot = sum[AW-1:0];
    end
  endfunction

  bdq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared compare unit: entry read last cycle against the search key
  assign match     = cmp_vld_r && (ram_rdata == value_r);
  assign find_done = match || (cmp_vld_r && (cmp_idx_r == occ_r - CW'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_FIND && occ_r != '0) begin
          state_nxt = S_FIND;
        end else begin
          state_nxt = S_BACK;
        end
      end
      S_FIND: begin
        if (find_done) begin
          state_nxt = S_BACK;
        end
      end
      S_BACK:      state_nxt = S_BACK_WAIT;
      S_BACK_WAIT: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
  end
  assign out_data = out_r;

  // datapath and store control
  always_comb begin
    front_nxt   = front_r;
    occ_nxt     = occ_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    op_nxt      = op_r;
    value_nxt   = value_r;
    hit_nxt     = hit_r;
    pos_nxt     = pos_r;
    status_nxt  = status_r;
    out_nxt     = out_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = value_r;
    ram_re      = 1'b0;
    ram_raddr   = slot(front_r, rd_idx_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          value_nxt = in_data.value;
        end
      end

      // apply the operation to pointers and store
      S_EXEC: begin
        hit_nxt    = 1'b0;
        pos_nxt    = '0;
        status_nxt = ST_OK;
        rd_idx_nxt = '0;
        case (op_r)
          OP_PUSH_FRONT: begin
            if (occ_r == DEPTH_C) begin
              status_nxt = ST_FULL;
            end else begin
              front_nxt = (front_r == '0) ? LAST_A : front_r - AW'(1);
              ram_we    = 1'b1;
              ram_waddr = (front_r == '0) ? LAST_A : front_r - AW'(1);
              occ_nxt   = occ_r + CW'(1);
            end
          end
          OP_PUSH_BACK: begin
            if (occ_r == DEPTH_C) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot(front_r, occ_r);
              occ_nxt   = occ_r + CW'(1);
            end
          end
          OP_POP_FRONT: begin
            if (occ_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              front_nxt = slot(front_r, CW'(1));
              occ_nxt   = occ_r - CW'(1);
            end
          end
          OP_POP_BACK: begin
            if (occ_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              occ_nxt = occ_r - CW'(1);
            end
          end
          OP_CLEAR: begin
            front_nxt = '0;
            occ_nxt   = '0;
          end
          default: begin
          end
        endcase
      end

      // linear search: one read issued and one compare per cycle
      S_FIND: begin
        if (rd_idx_r != occ_r && !find_done) begin
          ram_re      = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        if (match) begin
          hit_nxt = 1'b1;
          pos_nxt = cmp_idx_r;
        end
      end

      // fetch the back entry
      S_BACK: begin
        ram_re    = (occ_r != '0);
        ram_raddr = slot(front_r, occ_r - CW'(1));
      end

      // build the result word
      S_BACK_WAIT: begin
        out_nxt.status     = status_r;
        out_nxt.hit        = hit_r;
        out_nxt.position   = POS_W'(pos_r);
        out_nxt.count      = CNT_W'(occ_r);
        out_nxt.is_empty   = (occ_r == '0);
        out_nxt.back_value = (occ_r != '0) ? ram_rdata : '0;
      end

      S_OUT: begin
      end

      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      occ_r     <= '0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      occ_r     <= occ_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    value_r   <= value_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_r     <= hit_nxt;
    pos_r     <= pos_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

endmodule

`default_nettype wire

@@ tb/bounded_deque_with_search_tb.sv @@
module bounded_deque_with_search_tb;
  import bdq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT    = 17;
  localparam int HOLD_LEN    = 250;

  // op codes the block treats as no operation
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  bounded_deque_with_search #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the deque
  logic signed [VAL_W-1:0] shadow_mem [DEPTH];
  logic [IDX_W-1:0]        shadow_front;
  logic [CNT_W-1:0]        shadow_count;

  out_word_t status_words_due[$];

  int  err_count    = 0;
  int  words_sent   = 0;
  int  words_seen   = 0;
  int  full_drops   = 0;
  int  empty_pops   = 0;
  int  find_hits    = 0;
  int  cycle_count  = 0;
  int  hold_cycles  = 0;
  bit  hold_req     = 1'b0;
  bit  hold_ack     = 1'b0;
  bit  idle_enable  = 1'b1;

  // shadow slot at a front-relative offset
  function automatic logic [IDX_W-1:0] shadow_slot(input int off);
    return IDX_W'((int'(shadow_front) + off) % DEPTH);
  endfunction

  // next deque state and the status word it reports
  function automatic out_word_t predict_deque(in_word_t w);
    out_word_t r;
    int        i;
    r = '0;
    r.status = ST_OK;
    case (w.op)
      OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_front = shadow_slot(DEPTH - 1);
          shadow_mem[shadow_front] = w.value;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[shadow_slot(int'(shadow_count))] = w.value;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_front = shadow_slot(1);
          shadow_count--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
        end
      end
      OP_FIND: begin
        for (i = 0; i < shadow_count; i++) begin
          if (r.hit == 1'b0 && shadow_mem[shadow_slot(i)] == w.value) begin
            r.hit      = 1'b1;
            r.position = i[POS_W-1:0];
          end
        end
      end
      OP_CLEAR: begin
        shadow_front = '0;
        shadow_count = '0;
      end
      default: ;
    endcase
    r.count    = shadow_count;
    r.is_empty = (shadow_count == 0);
    if (shadow_count != 0)
      r.back_value = shadow_mem[shadow_slot(int'(shadow_count) - 1)];
    if (r.status == ST_FULL) full_drops++;
    if (r.status == ST_EMPTY) empty_pops++;
    if (r.hit) find_hits++;
    return r;
  endfunction

  // offer one word, wait for it to be taken, then predict
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] value);
    in_word_t w;
    w.op    = op;
    w.value = value;
    if (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_words_due.push_back(predict_deque(w));
    words_sent++;
    @(negedge clk);
  endtask

  // sender pauses until every status word is back
  task automatic drain_results();
    in_valid = 1'b0;
    while (status_words_due.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // compare each taken status word with the oldest prediction
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (status_words_due.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, out_data);
        err_count++;
      end else begin
        e = status_words_due.pop_front();
        check_field("status", e.status, out_data.status);
        check_field("hit", e.hit, out_data.hit);
        check_field("position", e.position, out_data.position);
        check_field("count", e.count, out_data.count);
        check_field("is_empty", e.is_empty, out_data.is_empty);
        check_field("back_value", $signed(e.back_value), $signed(out_data.back_value));
      end
    end
  end

  // receiver: random stalls, or a counted hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack    = hold_req;
      hold_cycles = HOLD_LEN;
    end
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else if (idle_enable) begin
      out_stall = ($urandom_range(99) < IDLE_PCT);
    end else begin
      out_stall = 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bounded_deque_with_search verification failed");
      $finish;
    end
  end

  // ops on an empty store, unused codes
  task automatic test_empty_ops();
    send_word(OP_POP_FRONT, 32'sd1);
    send_word(OP_POP_BACK, -32'sd1);
    send_word(OP_FIND, 32'sd0);
    send_word(OP_CLEAR, 32'sd0);
    send_word(OP_SPARE_A, 32'sh5555_5555);
    send_word(OP_SPARE_B, 32'shAAAA_AAAA);
  endtask

  // value extremes, both push ends, find hit and miss, single-element pops
  task automatic test_extremes();
    send_word(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_word(OP_POP_FRONT, 32'sd0);
    send_word(OP_PUSH_FRONT, 32'sh8000_0000);
    send_word(OP_POP_BACK, 32'sd0);
    send_word(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    send_word(OP_PUSH_FRONT, 32'sh8000_0000);
    send_word(OP_PUSH_BACK, -32'sd1);
    send_word(OP_PUSH_BACK, 32'sd0);
    send_word(OP_PUSH_FRONT, -32'sd1);
    send_word(OP_FIND, -32'sd1);
    send_word(OP_FIND, 32'sd0);
    send_word(OP_FIND, 32'sh1234_5678);
    send_word(OP_SPARE_B, 32'sd0);
    send_word(OP_POP_BACK, 32'sd0);
    send_word(OP_POP_FRONT, 32'sd0);
    send_word(OP_CLEAR, 32'sd0);
    send_word(OP_CLEAR, 32'sd0);
  endtask

  // fill to the limit, push into a full store, find the last and first slots
  task automatic test_full_store();
    int i;
    for (i = 0; i < DEPTH; i++)
      send_word((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, i + 100);
    send_word(OP_PUSH_BACK, 32'sd7);
    send_word(OP_PUSH_FRONT, 32'sd7);
    send_word(OP_FIND, 32'sd115);
    send_word(OP_FIND, 32'sd114);
    send_word(OP_CLEAR, 32'sd0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int i;
    @(posedge clk);
    hold_req = ~hold_req;
    @(negedge clk);
    for (i = 0; i < 40; i++)
      send_word(i % 3 == 2 ? OP_FIND : OP_PUSH_BACK, $urandom_range(0, 7));
    drain_results();
    send_word(OP_CLEAR, 32'sd0);
    drain_results();
  endtask

  // pick a value: small pool for duplicates, extremes, or full random
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $signed($urandom_range(0, 7)) - 4;
    if (r < 60) return 32'sh7FFF_FFFF;
    if (r < 70) return 32'sh8000_0000;
    return $urandom;
  endfunction

  // mostly well-formed traffic with drifting fill level, a quiet stretch
  task automatic test_random(input int n_words);
    int                      i;
    int                      r;
    int                      push_bias;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] v;
    push_bias = 50;
    for (i = 0; i < n_words; i++) begin
      if (i % 80 == 0) push_bias = 20 + 30 * $urandom_range(0, 2);
      idle_enable = !(i >= 600 && i < 900);
      r = $urandom_range(99);
      if (r < 2) begin
        op = $urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A;
      end else if (r < 4) begin
        op = OP_CLEAR;
      end else if (r < 28) begin
        op = OP_FIND;
      end else if ($urandom_range(99) < push_bias) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      v = pick_value();
      if (op == OP_FIND && shadow_count != 0 && $urandom_range(99) < 60)
        v = shadow_mem[shadow_slot($urandom_range(0, int'(shadow_count) - 1))];
      send_word(op, v);
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    int lost_words;
    lost_words = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    shadow_front = '0;
    shadow_count = '0;
    foreach (shadow_mem[k]) shadow_mem[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_ops();
    test_extremes();
    test_full_store();
    drain_results();
    test_backpressure();
    test_random(1550);

    drain_results();
    repeat (40) @(negedge clk);
    lost_words = status_words_due.size();
    if (lost_words != 0) begin
      $display("%0t: %0d status words never arrived", $time, lost_words);
    end

    $display("Sent %0d words, checked %0d status words in %0d cycles.",
             words_sent, words_seen, cycle_count);
    $display("Full drops %0d, empty pops %0d, find hits %0d, mismatches %0d.",
             full_drops, empty_pops, find_hits, err_count);
    if (err_count == 0 && lost_words == 0) begin
      $display("bounded_deque_with_search verification clean");
    end else begin
      $display("bounded_deque_with_search verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bounded_deque_with_search.sv
tb/bounded_deque_with_search_tb.sv
